FILE: rtl/frwl_pkg.sv
// ----------------------------------------------------------------------------
// frwl_pkg
// Shared types and codes of the reader/writer lock manager.
// ----------------------------------------------------------------------------
package frwl_pkg;

	typedef enum logic [2:0] {
		OP_ACQ_SH  = 3'd0,
		OP_ACQ_EX  = 3'd1,
		OP_REL_SH  = 3'd2,
		OP_REL_EX  = 3'd3,
		OP_REL_ANY = 3'd4,
		OP_DOWN    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_RELEASED = 3'd2,
		ST_QFULL    = 3'd3,
		ST_TFULL    = 3'd4,
		ST_NOT_EX   = 3'd5,
		ST_UNKNOWN  = 3'd6
	} status_t;

	localparam logic [4:0] READER_MAX = 5'd31;
	localparam int         MAX_GRANTS = 8;

	// Classified request passed from front to back.
	typedef struct packed {
		logic [2:0]  opcode;
		logic [71:0] key;
		logic [3:0]  requester;
	} req_t;

	// Result word.
	typedef struct packed {
		logic [3:0] client;
		logic [2:0] status;
		logic       grant_mode;
		logic       last;
	} rsp_t;

endpackage

FILE: rtl/frwl_front.sv
// ----------------------------------------------------------------------------
// frwl_front
// Accepts requests, drops undefined opcodes and queues the rest.
// ----------------------------------------------------------------------------
module frwl_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           opcode,
	input  logic [7:0]           store_id,
	input  logic [63:0]          resource_id,
	input  logic [3:0]           requester,
	output logic                 req_valid,
	input  logic                 req_take,
	output frwl_pkg::req_t       req
);
	frwl_pkg::req_t fifo_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push, pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall && (opcode <= frwl_pkg::OP_DOWN);
	assign req_valid = (cnt_q != 2'd0);
	assign pop       = req_valid && req_take;
	assign req       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{opcode: opcode, key: {store_id, resource_id},
				requester: requester};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: rtl/frwl_back.sv
// ----------------------------------------------------------------------------
// frwl_back
// Looks up the lock table, applies the request and serves waiters one grant
// at a time, each through a queue slot read and an update; each word is held
// until the next one shows whether it is the last of its request.
// ----------------------------------------------------------------------------
module frwl_back #(
	parameter int LOCK_ENTRIES = 16,
	parameter int QUEUE_DEPTH  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_take,
	input  frwl_pkg::req_t req,
	output logic           out_valid,
	input  logic           out_stall,
	output frwl_pkg::rsp_t rsp
);
	localparam int EW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int GW = $clog2(frwl_pkg::MAX_GRANTS + 1);
	localparam int AW = (LOCK_ENTRIES * QUEUE_DEPTH > 1) ?
		$clog2(LOCK_ENTRIES * QUEUE_DEPTH) : 1;

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EXEC, S_SERVE, S_RD, S_SEND} state_t;

	logic [71:0]     key_q    [LOCK_ENTRIES];
	logic            vld_q    [LOCK_ENTRIES];
	logic [4:0]      rd_cnt_q [LOCK_ENTRIES];
	logic            wr_q     [LOCK_ENTRIES];
	logic [QW-1:0]   head_q   [LOCK_ENTRIES];
	logic [CW-1:0]   wcnt_q   [LOCK_ENTRIES];
	logic [4:0]      wmem     [LOCK_ENTRIES*QUEUE_DEPTH];

	state_t          state_q;
	frwl_pkg::req_t  cur_q;
	logic [EW-1:0]   ent_q;
	logic            hit_q;
	logic [4:0]      slot_q;
	logic [GW-1:0]   gcnt_q;
	logic            out_valid_q;
	frwl_pkg::rsp_t  rsp_q;
	frwl_pkg::rsp_t  pend_q;

	logic [EW-1:0]   hit_idx, free_idx;
	logic            hit, free_any;
	logic            is_acq;
	logic [QW-1:0]   tail;
	logic [QW:0]     tail_sum;
	logic [AW-1:0]   wr_addr, hd_addr;
	logic            wmem_we;
	logic [4:0]      wmem_wd;
	logic            out_free;
	logic            load;
	logic [4:0]      rc;
	logic            wh;
	logic [CW-1:0]   wc;
	logic            sh_grant, ex_grant;
	logic            serve_stop;

	assign is_acq = (cur_q.opcode == frwl_pkg::OP_ACQ_SH) ||
		(cur_q.opcode == frwl_pkg::OP_ACQ_EX);

	always_comb begin
		hit = 1'b0; hit_idx = '0; free_any = 1'b0; free_idx = '0;
		for (int i = LOCK_ENTRIES - 1; i >= 0; i--) begin
			if (vld_q[i] && key_q[i] == cur_q.key) begin
				hit = 1'b1; hit_idx = EW'(i);
			end
			if (!vld_q[i]) begin
				free_any = 1'b1; free_idx = EW'(i);
			end
		end
	end

	always_comb begin
		tail_sum = {1'b0, head_q[ent_q]} + (QW+1)'(wcnt_q[ent_q]);
		tail = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
			QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
	end

	assign wr_addr = AW'(ent_q * QUEUE_DEPTH + tail);
	assign hd_addr = AW'(ent_q * QUEUE_DEPTH + head_q[ent_q]);

	always_ff @(posedge clk) begin
		if (wmem_we) wmem[wr_addr] <= wmem_wd;
		slot_q <= wmem[hd_addr];
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign load      = out_free && (state_q == S_SEND || state_q == S_SERVE);
	assign out_valid = out_valid_q;
	assign rsp       = rsp_q;
	assign req_take  = (state_q == S_IDLE);

	always_comb begin
		rc = rd_cnt_q[ent_q];
		wh = wr_q[ent_q];
		wc = wcnt_q[ent_q];
		sh_grant = (cur_q.opcode == frwl_pkg::OP_ACQ_SH) && !wh && wc == '0 &&
			rc < frwl_pkg::READER_MAX;
		ex_grant = (cur_q.opcode == frwl_pkg::OP_ACQ_EX) && !wh && wc == '0 &&
			rc == '0;
		wmem_we = (state_q == S_EXEC) && hit_q && is_acq && !sh_grant && !ex_grant &&
			(wc < CW'(QUEUE_DEPTH));
		wmem_wd = {cur_q.requester, cur_q.opcode[0]};
		serve_stop = (wc == '0) || (gcnt_q == GW'(frwl_pkg::MAX_GRANTS)) ||
			(slot_q[0] && (rc != '0 || wh)) ||
			(!slot_q[0] && (wh || rc >= frwl_pkg::READER_MAX));
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LOCK_ENTRIES; i++) begin
			if (state_q == S_LOOK && !hit && free_any && free_idx == EW'(i) && is_acq) begin
				key_q[i] <= cur_q.key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			ent_q       <= '0;
			gcnt_q      <= '0;
			cur_q       <= '0;
			rsp_q       <= '0;
			pend_q      <= '0;
			for (int i = 0; i < LOCK_ENTRIES; i++) begin
				vld_q[i] <= 1'b0; rd_cnt_q[i] <= '0; wr_q[i] <= 1'b0;
				head_q[i] <= '0; wcnt_q[i] <= '0;
			end
		end else begin
			out_valid_q <= load || (out_valid_q && out_stall);
			if (load) begin
				rsp_q.client     <= pend_q.client;
				rsp_q.status     <= pend_q.status;
				rsp_q.grant_mode <= pend_q.grant_mode;
				rsp_q.last       <= (state_q == S_SEND) || serve_stop;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cur_q   <= req;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (hit) begin
						hit_q <= 1'b1; ent_q <= hit_idx;
					end else if (free_any && is_acq) begin
						hit_q <= 1'b1; ent_q <= free_idx;
						vld_q[free_idx] <= 1'b1; rd_cnt_q[free_idx] <= '0;
						wr_q[free_idx] <= 1'b0; head_q[free_idx] <= '0;
						wcnt_q[free_idx] <= '0;
					end else begin
						hit_q <= 1'b0;
					end
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					pend_q.client     <= cur_q.requester;
					pend_q.grant_mode <= hit_q && ex_grant;
					pend_q.last       <= 1'b0;
					gcnt_q            <= '0;
					state_q <= (hit_q && !is_acq && wc != '0) ? S_RD : S_SEND;
					if (!hit_q) begin
						pend_q.status <= is_acq ? frwl_pkg::ST_TFULL : frwl_pkg::ST_UNKNOWN;
					end else if (sh_grant) begin
						rd_cnt_q[ent_q] <= rc + 5'd1;
						pend_q.status <= frwl_pkg::ST_GRANTED;
					end else if (ex_grant) begin
						wr_q[ent_q] <= 1'b1;
						pend_q.status <= frwl_pkg::ST_GRANTED;
					end else if (is_acq) begin
						if (wmem_we) begin
							wcnt_q[ent_q] <= wc + CW'(1);
							pend_q.status <= frwl_pkg::ST_QUEUED;
						end else begin
							pend_q.status <= frwl_pkg::ST_QFULL;
						end
					end else begin
						case (cur_q.opcode)
							frwl_pkg::OP_REL_SH: begin
								if (rc != '0) rd_cnt_q[ent_q] <= rc - 5'd1;
								pend_q.status <= frwl_pkg::ST_RELEASED;
							end
							frwl_pkg::OP_REL_EX: begin
								wr_q[ent_q] <= 1'b0;
								pend_q.status <= frwl_pkg::ST_RELEASED;
							end
							frwl_pkg::OP_REL_ANY: begin
								if (wh && rc != '0) begin
									wr_q[ent_q] <= 1'b0; rd_cnt_q[ent_q] <= '0;
								end else if (wh) begin
									wr_q[ent_q] <= 1'b0;
								end else if (rc != '0) begin
									rd_cnt_q[ent_q] <= rc - 5'd1;
								end
								pend_q.status <= frwl_pkg::ST_RELEASED;
							end
							default: begin
								if (wh) begin
									wr_q[ent_q] <= 1'b0;
									if (rc < frwl_pkg::READER_MAX)
										rd_cnt_q[ent_q] <= rc + 5'd1;
									pend_q.status <= frwl_pkg::ST_GRANTED;
								end else begin
									pend_q.status <= frwl_pkg::ST_NOT_EX;
								end
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_SERVE;
				end
				S_SEND: begin
					if (out_free) state_q <= S_IDLE;
				end
				S_SERVE: begin
					if (out_free) begin
						if (serve_stop) begin
							state_q <= S_IDLE;
						end else begin
							if (slot_q[0]) wr_q[ent_q] <= 1'b1;
							else rd_cnt_q[ent_q] <= rc + 5'd1;
							head_q[ent_q] <= (head_q[ent_q] == QW'(QUEUE_DEPTH - 1)) ? '0
								: head_q[ent_q] + QW'(1);
							wcnt_q[ent_q] <= wc - CW'(1);
							gcnt_q <= gcnt_q + GW'(1);
							pend_q.client     <= slot_q[4:1];
							pend_q.status     <= frwl_pkg::ST_GRANTED;
							pend_q.grant_mode <= slot_q[0];
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/fair_rw_lock_manager_top.sv
// ----------------------------------------------------------------------------
// fair_rw_lock_manager_top
// Reader/writer lock manager with FIFO-fair waiter queues.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall; results leave on out_valid/out_stall.
// A word is taken on a clock edge with valid high and stall low.
// A two-entry request queue lets the front accept while the back works.
// Each request yields a reply, then after a release or downgrade zero or more
// grants to waiters; last marks the final word of a request.
// With the back end idle, a request passes the queue, lookup, update and
// output steps before out_valid rises; a release or downgrade that finds
// waiters also reads a queue slot before its reply.
// Each waiter grant adds a queue slot read and an update.
// The back end takes one request at a time and no new one until the last is
// done, as its lookup, update and output steps are serial.
// Undefined opcodes are dropped and give no result.
// Reset clears all locks, counts and queues at once.
// A stalled receiver holds the output word and freezes the back end; the
// front queue fills and then raises in_stall.
// ----------------------------------------------------------------------------
module fair_rw_lock_manager_top #(
	parameter int LOCK_ENTRIES = 16,
	parameter int QUEUE_DEPTH  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  store_id,
	input  logic [63:0] resource_id,
	input  logic [3:0]  requester,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  client,
	output logic [2:0]  status,
	output logic        grant_mode,
	output logic        last
);
	logic           req_valid, req_take;
	frwl_pkg::req_t req;
	frwl_pkg::rsp_t rsp;

	frwl_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.opcode, .store_id, .resource_id, .requester,
		.req_valid, .req_take, .req
	);

	frwl_back #(.LOCK_ENTRIES(LOCK_ENTRIES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .req_valid, .req_take, .req,
		.out_valid, .out_stall, .rsp
	);

	assign client     = rsp.client;
	assign status     = rsp.status;
	assign grant_mode = rsp.grant_mode;
	assign last       = rsp.last;
endmodule

FILE: rtl/frwl_checker.sv
// ----------------------------------------------------------------------------
// frwl_checker
// Port-level checks of the lock manager.
// ----------------------------------------------------------------------------
module frwl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic       grant_mode,
	input logic       last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("output word changed while stalled");
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grant_mode |-> status == frwl_pkg::ST_GRANTED)
		else $error("exclusive mode on a non-grant");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 3'd7)
		else $error("undefined status");
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == frwl_pkg::ST_TFULL || status == frwl_pkg::ST_UNKNOWN ||
			status == frwl_pkg::ST_QFULL || status == frwl_pkg::ST_QUEUED) |-> last)
		else $error("refusal not final");
endmodule

bind fair_rw_lock_manager_top frwl_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .status, .grant_mode, .last
);

FILE: tb/sv/fair_rw_lock_manager_checker.sv
// ----------------------------------------------------------------------------
// fair_rw_lock_manager_checker
// Watches both channels of the lock manager, keeps its own copy of the lock
// table, works out the reply and waiter grants of each accepted request and
// compares every result word against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module fair_rw_lock_manager_checker #(
	parameter int LOCK_ENTRIES = 16,
	parameter int QUEUE_DEPTH  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  store_id,
	input  logic [63:0] resource_id,
	input  logic [3:0]  requester,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  client,
	input  logic [2:0]  status,
	input  logic        grant_mode,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          words_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [3:0] who;
		logic       writer;
	} waiter_t;

	logic [71:0] tbl_key    [LOCK_ENTRIES];
	logic        tbl_valid  [LOCK_ENTRIES];
	logic [4:0]  tbl_readers[LOCK_ENTRIES];
	logic        tbl_writer [LOCK_ENTRIES];
	waiter_t     tbl_wait   [LOCK_ENTRIES][QUEUE_DEPTH];
	int          tbl_head   [LOCK_ENTRIES];
	int          tbl_count  [LOCK_ENTRIES];

	frwl_pkg::rsp_t expected_words[$];

	function automatic void push_word(logic [3:0] who, frwl_pkg::status_t st, logic mode);
		frwl_pkg::rsp_t w;
		w.client     = who;
		w.status     = st;
		w.grant_mode = mode;
		w.last       = 1'b0;
		expected_words.push_back(w);
	endfunction

	function automatic void mark_last();
		expected_words[expected_words.size()-1].last = 1'b1;
	endfunction

	function automatic void serve_waiters(int e);
		int granted;
		waiter_t s;
		granted = 0;
		while (tbl_count[e] > 0 && granted < frwl_pkg::MAX_GRANTS) begin
			s = tbl_wait[e][tbl_head[e]];
			if (s.writer) begin
				if (tbl_readers[e] != 0 || tbl_writer[e]) break;
				tbl_writer[e] = 1'b1;
			end else begin
				if (tbl_writer[e] || tbl_readers[e] >= frwl_pkg::READER_MAX) break;
				tbl_readers[e]++;
			end
			tbl_head[e] = (tbl_head[e] + 1) % QUEUE_DEPTH;
			tbl_count[e]--;
			push_word(s.who, frwl_pkg::ST_GRANTED, s.writer);
			granted++;
			if (s.writer) break;
		end
	endfunction

	function automatic void predict_request(logic [2:0] op, logic [71:0] key,
		logic [3:0] who);
		int e;
		e = -1;
		if (op > frwl_pkg::OP_DOWN) return;
		for (int i = 0; i < LOCK_ENTRIES; i++)
			if (e < 0 && tbl_valid[i] && tbl_key[i] == key) e = i;
		if (op == frwl_pkg::OP_ACQ_SH || op == frwl_pkg::OP_ACQ_EX) begin
			if (e < 0) begin
				for (int i = 0; i < LOCK_ENTRIES; i++)
					if (e < 0 && !tbl_valid[i]) e = i;
				if (e < 0) begin
					push_word(who, frwl_pkg::ST_TFULL, 1'b0);
					mark_last();
					return;
				end
				tbl_valid[e] = 1'b1;
				tbl_key[e] = key;
				tbl_readers[e] = '0;
				tbl_writer[e] = 1'b0;
				tbl_head[e] = 0;
				tbl_count[e] = 0;
			end
			if (op == frwl_pkg::OP_ACQ_SH && !tbl_writer[e] && tbl_count[e] == 0 &&
			    tbl_readers[e] < frwl_pkg::READER_MAX) begin
				tbl_readers[e]++;
				push_word(who, frwl_pkg::ST_GRANTED, 1'b0);
			end else if (op == frwl_pkg::OP_ACQ_EX && !tbl_writer[e] && tbl_count[e] == 0 &&
			             tbl_readers[e] == 0) begin
				tbl_writer[e] = 1'b1;
				push_word(who, frwl_pkg::ST_GRANTED, 1'b1);
			end else if (tbl_count[e] < QUEUE_DEPTH) begin
				tbl_wait[e][(tbl_head[e] + tbl_count[e]) % QUEUE_DEPTH] =
					'{who: who, writer: (op == frwl_pkg::OP_ACQ_EX)};
				tbl_count[e]++;
				push_word(who, frwl_pkg::ST_QUEUED, 1'b0);
			end else
				push_word(who, frwl_pkg::ST_QFULL, 1'b0);
			mark_last();
			return;
		end
		if (e < 0) begin
			push_word(who, frwl_pkg::ST_UNKNOWN, 1'b0);
			mark_last();
			return;
		end
		case (op)
			frwl_pkg::OP_REL_SH: begin
				if (tbl_readers[e] > 0) tbl_readers[e]--;
				push_word(who, frwl_pkg::ST_RELEASED, 1'b0);
			end
			frwl_pkg::OP_REL_EX: begin
				tbl_writer[e] = 1'b0;
				push_word(who, frwl_pkg::ST_RELEASED, 1'b0);
			end
			frwl_pkg::OP_REL_ANY: begin
				if (tbl_writer[e] && tbl_readers[e] != 0) begin
					tbl_writer[e] = 1'b0;
					tbl_readers[e] = '0;
				end else if (tbl_writer[e])
					tbl_writer[e] = 1'b0;
				else if (tbl_readers[e] != 0)
					tbl_readers[e]--;
				push_word(who, frwl_pkg::ST_RELEASED, 1'b0);
			end
			default: begin
				if (tbl_writer[e]) begin
					tbl_writer[e] = 1'b0;
					if (tbl_readers[e] < frwl_pkg::READER_MAX) tbl_readers[e]++;
					push_word(who, frwl_pkg::ST_GRANTED, 1'b0);
				end else
					push_word(who, frwl_pkg::ST_NOT_EX, 1'b0);
			end
		endcase
		serve_waiters(e);
		mark_last();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frwl_pkg::rsp_t w;
		if (!arst_n) begin
			fail_count <= 0;
			words_seen <= 0;
			pending    <= 0;
			expected_words.delete();
			for (int i = 0; i < LOCK_ENTRIES; i++) begin
				tbl_valid[i]   = 1'b0;
				tbl_readers[i] = '0;
				tbl_writer[i]  = 1'b0;
				tbl_head[i]    = 0;
				tbl_count[i]   = 0;
			end
		end else begin
			if (out_valid && !out_stall) begin
				words_seen <= words_seen + 1;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word client=%0d status=%0d mode=%0d last=%0d",
						$time, client, status, grant_mode, last);
					fail_count <= fail_count + 1;
				end else begin
					w = expected_words.pop_front();
					if (w.client !== client || w.status !== status ||
					    w.grant_mode !== grant_mode || w.last !== last) begin
						$display("%0t: mismatch expected client=%0d status=%0d mode=%0d last=%0d",
							$time, w.client, w.status, w.grant_mode, w.last);
						$display("%0t:          actual   client=%0d status=%0d mode=%0d last=%0d",
							$time, client, status, grant_mode, last);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_request(opcode, {store_id, resource_id}, requester);
			pending <= expected_words.size();
		end
	end
endmodule

FILE: tb/sv/fair_rw_lock_manager_top_tb.sv
// ----------------------------------------------------------------------------
// fair_rw_lock_manager_top_tb
// Drives lock requests into the lock manager: a directed opening over every
// opcode and status, then random traffic on a small key set with random
// idling on both sides and one long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module fair_rw_lock_manager_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [7:0]  store_id = '0;
	logic [63:0] resource_id = '0;
	logic [3:0]  requester = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  client;
	logic [2:0]  status;
	logic        grant_mode;
	logic        last;
	int          fail_count;
	int          pending;
	int          words_seen;
	int          send_idle_pct = 7;
	int          recv_idle_pct = 87;
	bit          hold_off = 1'b0;
	int          sent = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	fair_rw_lock_manager_top dut (.*);

	fair_rw_lock_manager_checker chk (.*);

	initial begin
		#5ms;
		$display("** fair_rw_lock_manager_top: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_word(logic [2:0] op, logic [7:0] st, logic [63:0] res, logic [3:0] who);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		store_id    <= st;
		resource_id <= res;
		requester   <= who;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	function automatic logic [63:0] pick_resource(int k);
		case (k)
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_phase(int count);
		logic [2:0]  op;
		logic [63:0] res;
		for (int i = 0; i < count; i++) begin
			res = pick_resource($urandom_range(2));
			if ($urandom_range(9) == 0) res = {$urandom, $urandom};
			if ($urandom_range(19) == 0) op = 3'($urandom_range(7, 6));
			else op = 3'($urandom_range(frwl_pkg::OP_DOWN));
			send_word(op, $urandom_range(1) ? 8'hFF : 8'h00, res, 4'($urandom_range(15)));
		end
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_word(frwl_pkg::OP_REL_SH, 8'h00, 64'd0, 4'd0);
		send_word(frwl_pkg::OP_ACQ_SH, 8'h00, 64'd0, 4'd1);
		send_word(frwl_pkg::OP_ACQ_SH, 8'h00, 64'd0, 4'd2);
		send_word(frwl_pkg::OP_ACQ_EX, 8'h00, 64'd0, 4'd3);
		send_word(frwl_pkg::OP_ACQ_SH, 8'h00, 64'd0, 4'd4);
		send_word(frwl_pkg::OP_REL_SH, 8'h00, 64'd0, 4'd1);
		send_word(frwl_pkg::OP_REL_ANY, 8'h00, 64'd0, 4'd2);
		send_word(frwl_pkg::OP_DOWN, 8'h00, 64'd0, 4'd3);
		send_word(frwl_pkg::OP_DOWN, 8'h00, 64'd0, 4'd3);
		send_word(3'd7, 8'h00, 64'd0, 4'd5);
		send_word(frwl_pkg::OP_ACQ_EX, 8'hFF, '1, 4'd15);
		send_word(frwl_pkg::OP_ACQ_SH, 8'hFF, '1, 4'd6);
		send_word(frwl_pkg::OP_REL_EX, 8'hFF, '1, 4'd15);
		send_word(frwl_pkg::OP_ACQ_EX, 8'hFF, '1, 4'd7);
		send_word(frwl_pkg::OP_DOWN, 8'hFF, '1, 4'd7);
		send_word(frwl_pkg::OP_REL_ANY, 8'hFF, '1, 4'd7);
		for (int i = 0; i < 9; i++)
			send_word(frwl_pkg::OP_ACQ_SH, 8'hFF, '1, i[3:0]);
		for (int i = 0; i < 16; i++)
			send_word(frwl_pkg::OP_ACQ_EX, 8'h5A, 64'(i) << 50, 4'd9);
		in_valid <= 1'b0;
		drain();
		random_phase(53);
		drain();
		send_idle_pct = 87;
		recv_idle_pct = 7;
		random_phase(53);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(53);
		join
		drain();
		$display("Sent %0d requests, checked %0d result words over directed, idling and",
			sent, words_seen);
		$display("hold-off phases on a small shared key set.");
		if (fail_count == 0)
			$display("** fair_rw_lock_manager_top: PASSED **");
		else
			$display("** fair_rw_lock_manager_top: FAILED **");
		$finish;
	end
endmodule
